FILE: src/multi_waveform_oscillator_bank_macros.svh
// Assertion macros shared by the oscillator bank RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MULTI_WAVEFORM_OSCILLATOR_BANK_MACROS_SVH
`define MULTI_WAVEFORM_OSCILLATOR_BANK_MACROS_SVH

// same-cycle implication
`define MWOB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MWOB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/mwob_pkg.sv
// Shared constants, types and the sine table generator for the oscillator bank.
// No dependencies.
package mwob_pkg;

   localparam int NUM_OSC_DEFAULT    = 3;
   localparam int SINE_DEPTH_DEFAULT = 256;
   localparam int MAX_OSC            = 3;

   localparam int PHASE_W  = 32;
   localparam int WAVE_W   = 17;   // Q1.15 value in [-1, +1]
   localparam int SUM_W    = 18;
   localparam int SAMPLE_W = 18;
   localparam int GAIN_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WAVE_A       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_A       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WAVE_B       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_B       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WAVE_C       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_C       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN         = 3'd7;

   // waveform codes
   localparam logic [1:0] WAVE_SINE     = 2'd0;
   localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
   localparam logic [1:0] WAVE_SAW      = 2'd2;
   localparam logic [1:0] WAVE_SQUARE   = 2'd3;

   // reset values
   localparam logic [1:0]         RST_ACTIVE_COUNT = 2'd1;
   localparam logic [1:0]         RST_WAVE_A       = WAVE_SQUARE;
   localparam logic [1:0]         RST_WAVE_B       = WAVE_SAW;
   localparam logic [1:0]         RST_WAVE_C       = WAVE_SAW;
   localparam logic [PHASE_W-1:0] RST_STEP_A       = 32'd39370534;
   localparam logic [PHASE_W-1:0] RST_STEP_B       = 32'd39415274;
   localparam logic [PHASE_W-1:0] RST_STEP_C       = 32'd39281054;
   localparam logic [GAIN_W-1:0]  RST_GAIN         = 16'd16384;

   localparam logic [GAIN_W-1:0] Q15_ONE = 16'd32768;
   localparam logic [63:0]       Q30_ONE = 64'd1073741824;
   localparam logic [63:0]       Q30_PI  = 64'd3373259426;

   typedef struct packed {
      logic       adv;   // pipeline moves this cycle
      logic       en;    // oscillator is summed
      logic [1:0] sel;   // waveform code
   } osc_ctl_type;

   // Q1.15 sine of x (Q30 radians, 0..pi/2), Taylor series in Q30
   function automatic logic [15:0] sine_from_x(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s + 64'd16384) >> 15;
      if (v > 64'd32768) v = 64'd32768;
      return v[15:0];
   endfunction

endpackage

FILE: src/mwob_if.sv
// Valid/ready channel interfaces for tick requests and sample responses.
// Depends on mwob_pkg for the sample width.
interface mwob_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface mwob_rsp_if import mwob_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: src/mwob_osc_wave.sv
// One oscillator's waveform shaper: phase to Q1.15 value, with a sine quarter ROM.
// Depends on mwob_pkg (codes, ctl struct, sine generator).
module mwob_osc_wave import mwob_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  osc_ctl_type              ctl,
   input  logic [PHASE_W-1:0]       phase,
   output logic signed [WAVE_W-1:0] wave_out
);

   localparam int IdxW  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int ProdW = 30 + IdxW;

   logic [15:0] rom [SINE_TABLE_DEPTH+1];

   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [63:0] XK = (Q30_PI * 64'(k)) / (64'(2 * SINE_TABLE_DEPTH));
      assign rom[k] = sine_from_x(XK);
   end

   logic [ProdW-1:0]       idx_prod;
   logic [IdxW-1:0]        idx_fwd;
   logic [IdxW-1:0]        idx_in;
   logic signed [WAVE_W-1:0] shape_in;
   logic [PHASE_W-1:0]     tri_dist;
   logic signed [WAVE_W:0] tri_val;

   logic [IdxW-1:0]          idx_ff;
   logic                     neg_ff;
   logic [1:0]               sel_ff;
   logic                     en_ff;
   logic signed [WAVE_W-1:0] shape_ff;

   always_comb begin
      idx_prod = {{IdxW{1'b0}}, phase[29:0]} * ProdW'(SINE_TABLE_DEPTH);
      idx_fwd  = idx_prod[ProdW-1:30];
      // odd quadrants run the table backwards
      idx_in   = phase[30] ? IdxW'(SINE_TABLE_DEPTH) - idx_fwd : idx_fwd;

      tri_dist = phase[31] ? {1'b0, phase[30:0]} : 32'h8000_0000 - phase;
      tri_val  = $signed({2'b00, Q15_ONE}) - $signed({1'b0, tri_dist[31:15]});

      case (ctl.sel)
         WAVE_TRIANGLE: shape_in = tri_val[WAVE_W-1:0];
         WAVE_SAW:      shape_in = {~phase[31], ~phase[31], phase[30:16]};
         WAVE_SQUARE: begin
            shape_in = (phase != '0 && !phase[31]) ? $signed({1'b0, Q15_ONE})
                                                   : -$signed({1'b0, Q15_ONE});
         end
         default:       shape_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         idx_ff   <= idx_in;
         neg_ff   <= phase[31];
         sel_ff   <= ctl.sel;
         en_ff    <= ctl.en;
         shape_ff <= shape_in;
      end
   end

   logic signed [WAVE_W-1:0] sine_val;

   always_comb begin
      sine_val = neg_ff ? -$signed({1'b0, rom[idx_ff]}) : $signed({1'b0, rom[idx_ff]});
      if (!en_ff)
         wave_out = '0;
      else if (sel_ff == WAVE_SINE)
         wave_out = sine_val;
      else
         wave_out = shape_ff;
   end

endmodule

FILE: src/multi_waveform_oscillator_bank.sv
// Oscillator bank: one sample per tick, carried by stage valids s1, s2, s3 and out from accept to result valid.
// Throughput one word per cycle: phase register, waveform shaping, table lookup and
// sum, then the gain multiply each take one pipeline stage; a stalled result stalls all.
// Synchronous reset clears phases and stage valids and loads register defaults.
// Depends on mwob_pkg, mwob_if, mwob_osc_wave and the assertion macro header.
`include "multi_waveform_oscillator_bank_macros.svh"

module multi_waveform_oscillator_bank import mwob_pkg::*; #(
   parameter int NUM_OSC          = NUM_OSC_DEFAULT,
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   mwob_req_if.sink              req_port,
   mwob_rsp_if.source            rsp_port,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [1:0]         active_count_ff;
   logic [1:0]         wave_ff [MAX_OSC];
   logic [PHASE_W-1:0] step_ff [MAX_OSC];
   logic [GAIN_W-1:0]  gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff <= RST_ACTIVE_COUNT;
         wave_ff[0]      <= RST_WAVE_A;
         wave_ff[1]      <= RST_WAVE_B;
         wave_ff[2]      <= RST_WAVE_C;
         step_ff[0]      <= RST_STEP_A;
         step_ff[1]      <= RST_STEP_B;
         step_ff[2]      <= RST_STEP_C;
         gain_ff         <= RST_GAIN;
      end else if (csr_we) begin
         case (csr_index)
            REG_ACTIVE_COUNT: active_count_ff <= csr_wdata[1:0];
            REG_WAVE_A:       wave_ff[0]      <= csr_wdata[1:0];
            REG_STEP_A:       step_ff[0]      <= csr_wdata;
            REG_WAVE_B:       wave_ff[1]      <= csr_wdata[1:0];
            REG_STEP_B:       step_ff[1]      <= csr_wdata;
            REG_WAVE_C:       wave_ff[2]      <= csr_wdata[1:0];
            REG_STEP_C:       step_ff[2]      <= csr_wdata;
            REG_GAIN:         gain_ff         <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control: everything moves together unless the result is stuck
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic adv;
   logic accept;

   assign adv            = !out_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && adv;
   assign req_port.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // phase accumulators and stage 1
   logic [PHASE_W-1:0]       phase_ff    [NUM_OSC];
   logic [PHASE_W-1:0]       s1_phase_ff [NUM_OSC];
   logic                     s1_en_ff    [NUM_OSC];
   logic signed [WAVE_W-1:0] wave_val    [NUM_OSC];

   for (genvar i = 0; i < NUM_OSC; i++) begin : g_osc
      logic [PHASE_W-1:0] cur_phase;
      logic               en;
      osc_ctl_type        ctl;

      assign cur_phase = req_port.restart ? '0 : phase_ff[i];
      assign en        = 2'(i) < active_count_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            phase_ff[i] <= '0;
         end else if (accept) begin
            phase_ff[i] <= en ? cur_phase + step_ff[i] : cur_phase;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            s1_phase_ff[i] <= cur_phase;
            s1_en_ff[i]    <= en;
         end
      end

      assign ctl.adv = adv;
      assign ctl.en  = s1_en_ff[i];
      assign ctl.sel = wave_ff[i];

      mwob_osc_wave #(
         .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
      ) u_wave (
         .clock    (clock),
         .ctl      (ctl),
         .phase    (s1_phase_ff[i]),
         .wave_out (wave_val[i])
      );
   end

   // stage 3: sum of the enabled oscillators
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] sum_ff;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NUM_OSC; i++)
         sum_in = sum_in + SUM_W'(wave_val[i]);
   end

   always_ff @(posedge clock) begin
      if (adv) sum_ff <= sum_in;
   end

   // stage 4: gain, floored back to Q2.15
   logic [GAIN_W-1:0]               gain_sat;
   logic signed [SUM_W+GAIN_W:0]    prod;
   logic signed [SAMPLE_W-1:0]      sample_ff;

   assign gain_sat = (gain_ff > Q15_ONE) ? Q15_ONE : gain_ff;
   assign prod     = sum_ff * $signed({1'b0, gain_sat});

   always_ff @(posedge clock) begin
      if (adv) sample_ff <= prod[SAMPLE_W+14:15];
   end

   assign rsp_port.valid      = out_valid_ff;
   assign rsp_port.sample_out = sample_ff;

   `MWOB_ASSERT_NEXT(a_restart_zero, clock, reset, accept && req_port.restart, s1_phase_ff[0] == '0, "restart did not clear the sampled phase")
   `MWOB_ASSERT_NEXT(a_count_zero_hold, clock, reset, accept && !req_port.restart && active_count_ff == 2'd0, phase_ff[0] == $past(phase_ff[0]), "phase moved with no oscillator enabled")
   `MWOB_ASSERT_NEXT(a_sum_to_out, clock, reset, s3_valid_ff && adv, out_valid_ff, "summed word did not reach the output register")

endmodule
